@@ sv/bgs_pkg.sv @@
// Shared types and constants for the battery gauge smoother.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package bgs_pkg;

    localparam int SAMPLE_W = 12;
    localparam int SMOOTH_W = 20;
    localparam int TICK_W   = 17;
    localparam int PERIOD_W = 16;
    localparam int WEIGHT_W = 10;
    localparam int MV_W     = 13;
    localparam int PCT_W    = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int DIV_STEPS  = 7;
    localparam int NUM_W      = 19;
    localparam int DEN_SH_W   = SAMPLE_W + DIV_STEPS - 1;

    localparam logic [TICK_W-1:0]   TICK_MAX   = 17'h1FFFF;
    localparam logic [10:0]         VOLT_MUL   = 11'd1853;
    localparam logic [PCT_W-1:0]    PCT_FULL   = 7'd100;
    localparam logic [10:0]         WEIGHT_ONE = 11'd1024;
    localparam logic [9:0]          ROUND_HALF = 10'd512;

    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH_WEIGHT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEASURE_PERIOD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPORT_PERIOD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_VOLTAGE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_RAW = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_RAW = 3'd5;

    typedef struct packed {
        logic tick;
        logic mul;
        logic fold;
        logic report;
        logic prep;
        logic div_step;
        logic load;
    } bgs_cmd_t;

    typedef struct packed {
        logic fold_due;
        logic report_due;
        logic out_free;
    } bgs_status_t;

endpackage

@@ sv/bgs_ctrl.sv @@
// Controller state machine for the battery gauge smoother.
// Depends on bgs_pkg; drives the datapath through bgs_cmd_t commands.
`timescale 1ns / 1ps

module bgs_ctrl
    import bgs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  bgs_status_t status,
    output bgs_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_TEST,
        S_MUL,
        S_FOLD,
        S_REPORT,
        S_PREP,
        S_DIV,
        S_OUT
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    logic [2:0] div_cnt_reg;
    logic [2:0] div_cnt_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        cmd          = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.tick   = 1'b1;
                    state_next = S_TEST;
                end
            end
            S_TEST:
            begin
                state_next = status.fold_due ? S_MUL : S_REPORT;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_FOLD;
            end
            S_FOLD:
            begin
                cmd.fold   = 1'b1;
                state_next = S_REPORT;
            end
            S_REPORT:
            begin
                if (status.report_due)
                begin
                    cmd.report = 1'b1;
                    state_next = S_PREP;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_PREP:
            begin
                cmd.prep     = 1'b1;
                div_cnt_next = 3'(DIV_STEPS - 1);
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (div_cnt_reg == 3'd0)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    div_cnt_next = div_cnt_reg - 3'd1;
                end
            end
            S_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            div_cnt_reg <= 3'd0;
        end
        else
        begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

endmodule

@@ sv/bgs_datapath.sv @@
// Datapath of the battery gauge smoother: configuration, counters, smoothing,
// voltage, percentage divider and output register. Depends on bgs_pkg.
`timescale 1ns / 1ps

module bgs_datapath
    import bgs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [SAMPLE_W-1:0]   adc_sample,
    input  bgs_cmd_t              cmd,
    output bgs_status_t           status,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  event_kind,
    output logic [PCT_W-1:0]      level_pct,
    output logic [MV_W-1:0]       voltage_mv,
    output logic [SAMPLE_W-1:0]   raw_level
);

    logic [WEIGHT_W-1:0] weight_reg;
    logic [PERIOD_W-1:0] measure_period_reg;
    logic [PERIOD_W-1:0] report_period_reg;
    logic [MV_W-1:0]     low_mv_reg;
    logic [SAMPLE_W-1:0] empty_raw_reg;
    logic [SAMPLE_W-1:0] full_raw_reg;

    logic [SMOOTH_W-1:0] smooth_reg;
    logic [TICK_W-1:0]   measure_ticks_reg;
    logic [TICK_W-1:0]   report_ticks_reg;
    logic [SAMPLE_W-1:0] sample_reg;

    logic [29:0]         prod_old_reg;
    logic [22:0]         prod_new_reg;
    logic [30:0]         fold_sum;

    logic [SAMPLE_W-1:0] raw_reg;
    logic [MV_W-1:0]     mv_reg;
    logic [NUM_W-1:0]    rem_reg;
    logic [DEN_SH_W-1:0] den_sh_reg;
    logic [PCT_W-1:0]    quot_reg;
    logic                zero_flag_reg;
    logic                full_flag_reg;

    logic                out_valid_reg;
    logic                event_reg;
    logic [PCT_W-1:0]    pct_reg;
    logic [MV_W-1:0]     volt_reg;
    logic [SAMPLE_W-1:0] raw_out_reg;

    logic [22:0]         mv_prod;
    logic [SAMPLE_W-1:0] diff;
    logic [SAMPLE_W-1:0] den;
    logic [NUM_W-1:0]    num;
    logic                rem_ge;
    logic [10:0]         new_weight;

    assign new_weight = WEIGHT_ONE - {1'b0, weight_reg};
    assign fold_sum   = {1'b0, prod_old_reg} + {8'd0, prod_new_reg} * 31'd256
                      + {21'd0, ROUND_HALF};
    assign mv_prod    = {11'd0, raw_reg} * {12'd0, VOLT_MUL};
    assign diff       = raw_reg - empty_raw_reg;
    assign den        = full_raw_reg - empty_raw_reg;
    assign num        = NUM_W'({7'd0, diff} * {12'd0, PCT_FULL});
    assign rem_ge     = (rem_reg >= {1'b0, den_sh_reg});

    assign status.fold_due   = (measure_ticks_reg > {1'b0, measure_period_reg});
    assign status.report_due = (report_ticks_reg > {1'b0, report_period_reg});
    assign status.out_free   = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign event_kind = event_reg;
    assign level_pct  = pct_reg;
    assign voltage_mv = volt_reg;
    assign raw_level  = raw_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg         <= 10'd922;
            measure_period_reg <= 16'd100;
            report_period_reg  <= 16'd1000;
            low_mv_reg         <= 13'd3500;
            empty_raw_reg      <= 12'd1980;
            full_raw_reg       <= 12'd2100;
            smooth_reg         <= '0;
            measure_ticks_reg  <= '0;
            report_ticks_reg   <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SMOOTH_WEIGHT:  weight_reg         <= cfg_data[WEIGHT_W-1:0];
                    CFG_MEASURE_PERIOD: measure_period_reg <= cfg_data;
                    CFG_REPORT_PERIOD:  report_period_reg  <= cfg_data;
                    CFG_LOW_VOLTAGE:    low_mv_reg         <= cfg_data[MV_W-1:0];
                    CFG_EMPTY_RAW:      empty_raw_reg      <= cfg_data[SAMPLE_W-1:0];
                    CFG_FULL_RAW:       full_raw_reg       <= cfg_data[SAMPLE_W-1:0];
                    default:            ;
                endcase
            end
            if (cmd.tick)
            begin
                if (measure_ticks_reg != TICK_MAX)
                begin
                    measure_ticks_reg <= measure_ticks_reg + 17'd1;
                end
                if (report_ticks_reg != TICK_MAX)
                begin
                    report_ticks_reg <= report_ticks_reg + 17'd1;
                end
            end
            if (cmd.fold)
            begin
                smooth_reg        <= fold_sum[29:10];
                measure_ticks_reg <= '0;
            end
            if (cmd.report)
            begin
                report_ticks_reg <= '0;
            end
            if (cmd.load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.tick)
        begin
            sample_reg <= adc_sample;
        end
        if (cmd.mul)
        begin
            prod_old_reg <= {20'd0, weight_reg} * {10'd0, smooth_reg};
            prod_new_reg <= {12'd0, new_weight} * {11'd0, sample_reg};
        end
        if (cmd.report)
        begin
            raw_reg <= smooth_reg[SMOOTH_W-1:8];
        end
        if (cmd.prep)
        begin
            mv_reg        <= mv_prod[22:10];
            rem_reg       <= num;
            den_sh_reg    <= {den, 6'd0};
            quot_reg      <= '0;
            zero_flag_reg <= (full_raw_reg <= empty_raw_reg) || (raw_reg <= empty_raw_reg);
            full_flag_reg <= (raw_reg >= full_raw_reg);
        end
        if (cmd.div_step)
        begin
            if (rem_ge)
            begin
                rem_reg <= rem_reg - {1'b0, den_sh_reg};
            end
            den_sh_reg <= {1'b0, den_sh_reg[DEN_SH_W-1:1]};
            quot_reg   <= {quot_reg[PCT_W-2:0], rem_ge};
        end
        if (cmd.load)
        begin
            event_reg   <= (mv_reg < low_mv_reg);
            volt_reg    <= mv_reg;
            raw_out_reg <= raw_reg;
            if (zero_flag_reg)
            begin
                pct_reg <= '0;
            end
            else if (full_flag_reg)
            begin
                pct_reg <= PCT_FULL;
            end
            else
            begin
                pct_reg <= quot_reg;
            end
        end
    end

endmodule

@@ sv/battery_gauge_smoother_core.sv @@
// Battery gauge smoother: one ADC sample per millisecond tick in, an
// occasional ping or low-battery report out. Uses bgs_pkg, bgs_ctrl and
// bgs_datapath.
//
// Usage: each transfer on the input channel (in_valid, in_ready, adc_sample)
// is one millisecond tick. Both tick counters advance; when the measure period
// is exceeded the sample is folded into the Q12.8 smoothed value, and when the
// report period is exceeded one report transfer is produced on the output
// channel (out_valid, out_ready, event_kind, level_pct, voltage_mv, raw_level).
// Configuration is written through cfg_we, cfg_index and cfg_data while idle.
//
// Timing: one item at a time. A tick passes a test state, the multiply and
// fold states when a fold is due, and a report check; a report adds setup
// plus a seven-step shift-subtract divider for the percentage, then a load
// into the output register, from which out_valid is driven.
// The output register lets the next tick be accepted while a report waits;
// if the receiver stalls, a following report waits in the controller until
// the register frees. Reset clears counters and smoothed value and restores
// the default configuration.
`timescale 1ns / 1ps

module battery_gauge_smoother_core
    import bgs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [SAMPLE_W-1:0]   adc_sample,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  event_kind,
    output logic [PCT_W-1:0]      level_pct,
    output logic [MV_W-1:0]       voltage_mv,
    output logic [SAMPLE_W-1:0]   raw_level
);

    bgs_cmd_t    cmd;
    bgs_status_t status;

    bgs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    bgs_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .adc_sample (adc_sample),
        .cmd        (cmd),
        .status     (status),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .event_kind (event_kind),
        .level_pct  (level_pct),
        .voltage_mv (voltage_mv),
        .raw_level  (raw_level)
    );

endmodule

@@ bench/bgs_report_checker.sv @@
// Report checker for the battery gauge smoother: watches the configuration port
// and both channels, predicts every report and compares it field by field.
// Depends on bgs_pkg for widths, constants and register indexes.
`timescale 1ns / 1ps

module bgs_report_checker
    import bgs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic [SAMPLE_W-1:0]   adc_sample,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic                  event_kind,
    input  logic [PCT_W-1:0]      level_pct,
    input  logic [MV_W-1:0]       voltage_mv,
    input  logic [SAMPLE_W-1:0]   raw_level,
    output int                    fail_count,
    output int                    outstanding
);

    typedef struct packed {
        logic                kind;
        logic [PCT_W-1:0]    pct;
        logic [MV_W-1:0]     mv;
        logic [SAMPLE_W-1:0] raw;
    } gauge_report_t;

    localparam logic [WEIGHT_W-1:0] DEF_WEIGHT      = 10'd922;
    localparam logic [PERIOD_W-1:0] DEF_MEASURE     = 16'd100;
    localparam logic [PERIOD_W-1:0] DEF_REPORT      = 16'd1000;
    localparam logic [MV_W-1:0]     DEF_LOW_MV      = 13'd3500;
    localparam logic [SAMPLE_W-1:0] DEF_EMPTY       = 12'd1980;
    localparam logic [SAMPLE_W-1:0] DEF_FULL        = 12'd2100;

    logic [WEIGHT_W-1:0] weight;
    logic [PERIOD_W-1:0] measure_period;
    logic [PERIOD_W-1:0] report_period;
    logic [MV_W-1:0]     low_mv;
    logic [SAMPLE_W-1:0] empty_pt;
    logic [SAMPLE_W-1:0] full_pt;

    logic [SMOOTH_W-1:0] smoothed;
    logic [TICK_W-1:0]   measure_cnt;
    logic [TICK_W-1:0]   report_cnt;

    gauge_report_t expected_reports[$];

    function automatic logic [PCT_W-1:0] charge_percent(input logic [SAMPLE_W-1:0] raw);
        if (full_pt <= empty_pt || raw <= empty_pt)
            return '0;
        if (raw >= full_pt)
            return PCT_FULL;
        return PCT_W'((int'(raw - empty_pt) * int'(PCT_FULL)) / int'(full_pt - empty_pt));
    endfunction

    // Advances both tick counters, folds the sample in when due and returns 1 with
    // the report when one falls due on this tick.
    function automatic bit take_tick(input logic [SAMPLE_W-1:0] sample,
                                     output gauge_report_t rep);
        logic [39:0] acc;
        int          mv;
        rep = '0;
        measure_cnt = (measure_cnt == TICK_MAX) ? measure_cnt : measure_cnt + 1'b1;
        report_cnt  = (report_cnt == TICK_MAX) ? report_cnt : report_cnt + 1'b1;
        if (measure_cnt > {1'b0, measure_period}) begin
            acc = 40'(weight) * 40'(smoothed)
                + 40'(WEIGHT_ONE - weight) * (40'(sample) << 8)
                + 40'(ROUND_HALF);
            smoothed = SMOOTH_W'(acc >> 10);
            measure_cnt = '0;
        end
        if (report_cnt <= {1'b0, report_period})
            return 1'b0;
        report_cnt = '0;
        rep.raw  = smoothed[SMOOTH_W-1:8];
        mv       = (int'(rep.raw) * int'(VOLT_MUL)) >> 10;
        rep.mv   = MV_W'(mv);
        rep.pct  = charge_percent(rep.raw);
        rep.kind = (rep.mv < low_mv);
        return 1'b1;
    endfunction

    function automatic int field_differs(input string name, input logic [15:0] want,
                                         input logic [15:0] got);
        if (got === want)
            return 0;
        $error("%s: expected %0d, got %0d", name, want, got);
        return 1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        gauge_report_t rep;
        gauge_report_t want;
        int            errs;
        if (!rst_n)
        begin
            weight         = DEF_WEIGHT;
            measure_period = DEF_MEASURE;
            report_period  = DEF_REPORT;
            low_mv         = DEF_LOW_MV;
            empty_pt       = DEF_EMPTY;
            full_pt        = DEF_FULL;
            smoothed       = '0;
            measure_cnt    = '0;
            report_cnt     = '0;
            expected_reports.delete();
            fail_count  <= 0;
            outstanding <= 0;
        end
        else
        begin
            errs = 0;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SMOOTH_WEIGHT:  weight         = cfg_data[WEIGHT_W-1:0];
                    CFG_MEASURE_PERIOD: measure_period = cfg_data[PERIOD_W-1:0];
                    CFG_REPORT_PERIOD:  report_period  = cfg_data[PERIOD_W-1:0];
                    CFG_LOW_VOLTAGE:    low_mv         = cfg_data[MV_W-1:0];
                    CFG_EMPTY_RAW:      empty_pt       = cfg_data[SAMPLE_W-1:0];
                    CFG_FULL_RAW:       full_pt        = cfg_data[SAMPLE_W-1:0];
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (expected_reports.size() == 0)
                begin
                    $error("report transfer with none expected: kind %0d, %0d%%, %0d mV, raw %0d",
                           event_kind, level_pct, voltage_mv, raw_level);
                    errs++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    errs += field_differs("event_kind", 16'(want.kind), 16'(event_kind));
                    errs += field_differs("level_pct", 16'(want.pct), 16'(level_pct));
                    errs += field_differs("voltage_mv", 16'(want.mv), 16'(voltage_mv));
                    errs += field_differs("raw_level", 16'(want.raw), 16'(raw_level));
                end
            end
            if (in_valid && in_ready)
            begin
                if (take_tick(adc_sample, rep))
                    expected_reports.push_back(rep);
            end
            fail_count  <= fail_count + errs;
            outstanding <= expected_reports.size();
        end
    end

endmodule

@@ bench/tb.sv @@
// Testbench top for battery_gauge_smoother_core: drives reset, configuration
// and millisecond ticks, and gives the verdict from the report checker.
// Depends on bgs_pkg, the block under test and bgs_report_checker.
`timescale 1ns / 1ps

module tb;
    import bgs_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
    localparam int RANDOM_TICKS  = 1150;
    localparam int SETTLE_CYCLES = 20;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index  = '0;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;
    logic                  in_valid   = 1'b0;
    logic [SAMPLE_W-1:0]   adc_sample = '0;
    logic                  out_ready  = 1'b0;
    logic                  calm       = 1'b0;
    logic                  in_ready;
    logic                  out_valid;
    logic                  event_kind;
    logic [PCT_W-1:0]      level_pct;
    logic [MV_W-1:0]       voltage_mv;
    logic [SAMPLE_W-1:0]   raw_level;
    int                    fail_count;
    int                    outstanding;

    battery_gauge_smoother_core dut (.*);

    bgs_report_checker report_check (.*);

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        out_ready <= calm || ($urandom_range(99) >= 18);
    end

    function automatic int clamp(input int v, input int hi);
        return (v < 0) ? 0 : ((v > hi) ? hi : v);
    endfunction

    task automatic send_tick(input logic [SAMPLE_W-1:0] sample);
        if (!calm)
        begin
            while ($urandom_range(99) < 18)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid   <= 1'b1;
        adc_sample <= sample;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic settle;
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_settings(input logic [CFG_DATA_W-1:0] weight, mper, rper,
                                  input logic [CFG_DATA_W-1:0] low, empty, full);
        logic [CFG_IDX_W-1:0]  regs [6] = '{CFG_SMOOTH_WEIGHT, CFG_MEASURE_PERIOD,
                                            CFG_REPORT_PERIOD, CFG_LOW_VOLTAGE,
                                            CFG_EMPTY_RAW, CFG_FULL_RAW};
        logic [CFG_DATA_W-1:0] vals [6];
        vals = '{weight, mper, rper, low, empty, full};
        for (int i = 0; i < 6; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            @(posedge clk);
        end
        cfg_index <= $urandom_range(1) ? CFG_SPARE_HI : CFG_SPARE_LO;
        cfg_data  <= CFG_DATA_W'($urandom_range(16'hFFFF));
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin : stimulus
        logic [SAMPLE_W-1:0] edge_set [10] = '{12'd0, 12'd4095, 12'd1980, 12'd1981, 12'd2040,
                                               12'd2099, 12'd2100, 12'd1934, 12'd1935, 12'd2101};
        logic [SAMPLE_W-1:0] slow_set [8]  = '{12'd1935, 12'd1934, 12'd4095, 12'd0,
                                               12'd2047, 12'd2048, 12'd1, 12'd4094};
        int items;
        int phase;
        int base;
        int level;
        int w;
        int mper;
        int rper;
        int low;
        int empty;
        int full;
        bit wild;
        items = 0;
        phase = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        settle();

        write_settings(16'd0, 16'd0, 16'd0, 16'd3500, 16'd1980, 16'd2100);
        foreach (edge_set[i])
            send_tick(edge_set[i]);
        settle();
        write_settings(16'hFFFF, 16'd0, 16'd0, 16'hE000, 16'hFFFF, 16'hF000);
        send_tick(12'd4095);
        send_tick(12'd0);
        send_tick(12'd4095);
        settle();
        write_settings(16'd0, 16'd2, 16'd3, 16'd3501, 16'd0, 16'd4095);
        foreach (slow_set[i])
            send_tick(slow_set[i]);

        while (items < RANDOM_TICKS)
        begin
            base = $urandom_range(4095);
            case ($urandom_range(3))
                0: w = $urandom_range(64);
                1: w = $urandom_range(1023);
                2: w = $urandom_range(1023, 896);
                default: w = $urandom_range(1) ? 1023 : 0;
            endcase
            mper  = ($urandom_range(3) == 0) ? $urandom_range(30) : $urandom_range(3);
            rper  = ($urandom_range(3) == 0) ? $urandom_range(40) : $urandom_range(4);
            empty = clamp(base - int'($urandom_range(300)), 4095);
            full  = clamp(empty + int'($urandom_range(400)), 4095);
            case ($urandom_range(7))
                0: full = empty;
                1: empty = $urandom_range(4095);
                default: ;
            endcase
            if ($urandom_range(4) == 0)
                low = $urandom_range(8191);
            else
                low = clamp(((base * int'(VOLT_MUL)) >> 10) + int'($urandom_range(400)) - 200,
                            8191);
            settle();
            write_settings(16'(w) | (16'($urandom_range(63)) << WEIGHT_W), 16'(mper),
                           16'(rper), 16'(low) | (16'($urandom_range(7)) << MV_W),
                           16'(empty) | (16'($urandom_range(15)) << SAMPLE_W),
                           16'(full) | (16'($urandom_range(15)) << SAMPLE_W));
            calm <= (phase >= 6 && phase < 10);
            wild  = ($urandom_range(3) == 0);
            level = base;
            repeat ($urandom_range(60, 20))
            begin
                level = clamp(level + int'($urandom_range(40)) - 20, 4095);
                if (wild || $urandom_range(19) == 0)
                    send_tick(SAMPLE_W'($urandom_range(4095)));
                else
                    send_tick(SAMPLE_W'(clamp(level + int'($urandom_range(16)) - 8, 4095)));
                items++;
            end
            phase++;
        end

        settle();

        if (fail_count == 0 && outstanding == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #50_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
